FILE: rtl/djk_pkg.sv
package djk_pkg;

    localparam int JOINTS   = 5;
    localparam int EW       = 34;
    localparam int LW       = 42;
    localparam int AW       = 70;
    localparam int ITER_MAX = 24;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [35:0] ONE_Q       = 36'sd268435456;

    localparam logic [2:0] CFG_BASE_HEIGHT      = 3'd0;
    localparam logic [2:0] CFG_UPPER_ARM_LENGTH = 3'd1;
    localparam logic [2:0] CFG_FOREARM_LENGTH   = 3'd2;
    localparam logic [2:0] CFG_TOOL_LENGTH      = 3'd3;
    localparam logic [2:0] CFG_ELBOW_OFFSET     = 3'd4;

    localparam logic REQ_POSE     = 1'b0;
    localparam logic REQ_JACOBIAN = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] joint_angle_0;
        logic signed [15:0] joint_angle_1;
        logic signed [15:0] joint_angle_2;
        logic signed [15:0] joint_angle_3;
        logic signed [15:0] joint_angle_4;
        logic [2:0]         frame_count;
    } request_t;

    typedef struct packed {
        logic                     jacobian;
        logic [JOINTS-1:0][15:0]  angle;
        logic [2:0]               count;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         line_index;
        logic signed [23:0] value_0;
        logic signed [23:0] value_1;
        logic signed [23:0] value_2;
        logic signed [23:0] value_3;
        logic signed [23:0] value_4;
        logic signed [23:0] value_5;
        logic               last;
    } result_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd843314856;
            5'd1:    r = 32'd497837829;
            5'd2:    r = 32'd263043836;
            5'd3:    r = 32'd133525158;
            5'd4:    r = 32'd67021686;
            5'd5:    r = 32'd33543515;
            5'd6:    r = 32'd16775850;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194282;
            5'd9:    r = 32'd2097149;
            5'd10:   r = 32'd1048575;
            5'd11:   r = 32'd524287;
            5'd12:   r = 32'd262143;
            5'd13:   r = 32'd131071;
            5'd14:   r = 32'd65535;
            5'd15:   r = 32'd32767;
            5'd16:   r = 32'd16383;
            5'd17:   r = 32'd8191;
            5'd18:   r = 32'd4095;
            5'd19:   r = 32'd2047;
            5'd20:   r = 32'd1023;
            5'd21:   r = 32'd511;
            5'd22:   r = 32'd255;
            5'd23:   r = 32'd127;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [LW-1:0] q28);
        logic signed [LW-1:0] v;
        logic signed [23:0]   r;
        v = (q28 + 42'sd128) >>> 8;
        if (v > 42'sd8388607)
        begin
            r = 24'sd8388607;
        end
        else if (v < -42'sd8388608)
        begin
            r = -24'sd8388608;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/djk_fifo.sv
module djk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/djk_front.sv
module djk_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  djk_pkg::request_t request,
    output logic              full,
    input  logic              cmd_pop,
    output djk_pkg::cmd_t     cmd,
    output logic              cmd_empty
);

    djk_pkg::cmd_t                   cls;
    logic [$bits(djk_pkg::cmd_t)-1:0] q_rdata;

    always_comb
    begin
        cls.jacobian = (request.req_type == djk_pkg::REQ_JACOBIAN);
        cls.angle[0] = request.joint_angle_0;
        cls.angle[1] = request.joint_angle_1;
        cls.angle[2] = request.joint_angle_2;
        cls.angle[3] = request.joint_angle_3;
        cls.angle[4] = request.joint_angle_4;
        if (request.frame_count > 3'(djk_pkg::JOINTS))
        begin
            cls.count = 3'(djk_pkg::JOINTS);
        end
        else
        begin
            cls.count = request.frame_count;
        end
    end

    djk_fifo #(
        .WIDTH($bits(djk_pkg::cmd_t)),
        .DEPTH(2)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (push),
        .wdata(cls),
        .full (full),
        .rd   (cmd_pop),
        .rdata(q_rdata),
        .empty(cmd_empty)
    );

    assign cmd = djk_pkg::cmd_t'(q_rdata);

endmodule

FILE: rtl/djk_back.sv
module djk_back #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [19:0]      cfg_data,
    input  djk_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output djk_pkg::result_t res,
    input  logic             res_full,
    output logic             res_push
);

    localparam int ITER_N = (CORDIC_ITERATIONS > djk_pkg::ITER_MAX) ?
                            djk_pkg::ITER_MAX : CORDIC_ITERATIONS;
    localparam int IW = $clog2(ITER_N);
    localparam int EW = djk_pkg::EW;
    localparam int LW = djk_pkg::LW;
    localparam int AW = djk_pkg::AW;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RED  = 9'b000000010,
        S_ROT  = 9'b000000100,
        S_CS   = 9'b000001000,
        S_LNK  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_COPY = 9'b001000000,
        S_JAC  = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] base_height_reg, upper_arm_reg, forearm_reg, tool_reg;
    logic [12:0] elbow_reg;

    djk_pkg::cmd_t      cmd_reg, cmd_cur;
    logic [2:0]         link_reg, link_start;
    logic signed [33:0] x_reg, y_reg, x_step, y_step;
    logic signed [35:0] z_reg, z_step, z_start, atan_ext;
    logic               neg_reg;
    logic [IW-1:0]      it_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [EW-1:0] q03_reg, q13_reg;
    logic signed [EW-1:0] t_reg  [12];
    logic signed [EW-1:0] nt_reg [12];
    logic signed [31:0]   zs_reg [djk_pkg::JOINTS][3];
    logic signed [EW-1:0] os_reg [djk_pkg::JOINTS][3];
    logic signed [LW-1:0] lin_reg [3];
    logic [1:0]         row_reg, k_reg;
    logic [2:0]         col_reg;
    logic signed [67:0] prod_reg;
    logic               sub_reg;
    logic signed [AW-1:0] acc_reg, sum, init;
    logic signed [31:0] ma;
    logic signed [35:0] mb;
    logic               msub;
    logic [1:0]         nterms;
    logic               mac_done, start, in_range, last_link;
    logic signed [AW-1:0] rnd20, rnd28;
    logic signed [33:0] xr, yr;
    logic signed [35:0] d_vec [3];
    logic               right;
    logic [19:0]        a_len, d_len;
    logic signed [EW-1:0] col2 [3];
    logic signed [EW-1:0] col3 [3];

    // Link geometry.
    always_comb
    begin
        right = (link_reg == 3'd0) || (link_reg == 3'd3);
        a_len = 20'd0;
        d_len = 20'd0;
        case (link_reg)
            3'd0:    d_len = base_height_reg;
            3'd1:    a_len = upper_arm_reg;
            3'd2:    a_len = forearm_reg;
            3'd4:    d_len = tool_reg;
            default: a_len = 20'd0;
        endcase
    end

    assign cmd_cur = (state_reg == S_IDLE) ? cmd : cmd_reg;
    assign link_start = (state_reg == S_IDLE) ? 3'd0 : link_reg + 3'd1;

    always_comb
    begin
        logic signed [35:0] ang;
        logic signed [35:0] e30;
        logic [15:0]        j;
        j   = cmd_cur.angle[link_start];
        ang = {{3{j[15]}}, j, 17'd0};
        e30 = {6'd0, elbow_reg, 17'd0};
        case (link_start)
            3'd1:    z_start = ang + djk_pkg::HALF_PI_Q30 - e30;
            3'd2:    z_start = ang + e30 - djk_pkg::PI_Q30;
            3'd3:    z_start = ang + djk_pkg::HALF_PI_Q30;
            default: z_start = ang;
        endcase
    end

    // Frame of the link about to start: identity at the base, else the new product.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (state_reg == S_IDLE)
            begin
                col2[r] = (r == 2) ? EW'(djk_pkg::ONE_Q) : '0;
                col3[r] = '0;
            end
            else
            begin
                col2[r] = nt_reg[r*4+2];
                col3[r] = nt_reg[r*4+3];
            end
        end
    end

    // CORDIC step.
    always_comb
    begin
        atan_ext = 36'(djk_pkg::atan_q30(5'(it_reg)));
        if (z_reg >= 0)
        begin
            x_step = x_reg - (y_reg >>> it_reg);
            y_step = y_reg + (x_reg >>> it_reg);
            z_step = z_reg - atan_ext;
        end
        else
        begin
            x_step = x_reg + (y_reg >>> it_reg);
            y_step = y_reg - (x_reg >>> it_reg);
            z_step = z_reg + atan_ext;
        end
        in_range = (z_reg <= djk_pkg::PI_Q30) && (z_reg > -djk_pkg::PI_Q30);
        xr = (x_reg + 34'sd2) >>> 2;
        yr = (y_reg + 34'sd2) >>> 2;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_diff
        assign d_vec[g] = 36'(t_reg[g*4+3]) - 36'(os_reg[col_reg][g]);
    end

    function automatic logic signed [35:0] qsel(
        input logic [1:0] r, input logic [1:0] c, input logic rt,
        input logic signed [31:0] cv, input logic signed [31:0] sv,
        input logic signed [EW-1:0] q03, input logic signed [EW-1:0] q13,
        input logic [19:0] d);
        logic signed [35:0] v;
        v = '0;
        case ({r, c})
            4'b0000: v = 36'(cv);
            4'b0001: v = rt ? 36'sd0 : -36'(sv);
            4'b0010: v = rt ? 36'(sv) : 36'sd0;
            4'b0011: v = 36'(q03);
            4'b0100: v = 36'(sv);
            4'b0101: v = rt ? 36'sd0 : 36'(cv);
            4'b0110: v = rt ? -36'(cv) : 36'sd0;
            4'b0111: v = 36'(q13);
            4'b1001: v = rt ? djk_pkg::ONE_Q : 36'sd0;
            4'b1010: v = rt ? 36'sd0 : djk_pkg::ONE_Q;
            4'b1011: v = {8'd0, d, 8'd0};
            default: v = '0;
        endcase
        return v;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb
    begin
        logic [1:0] a1, a2;
        ma     = '0;
        mb     = '0;
        msub   = 1'b0;
        init   = '0;
        nterms = 2'd1;
        a1     = 2'd1;
        a2     = 2'd2;
        case (row_reg)
            2'd1:    begin a1 = 2'd2; a2 = 2'd0; end
            2'd2:    begin a1 = 2'd0; a2 = 2'd1; end
            default: begin a1 = 2'd1; a2 = 2'd2; end
        endcase
        case (state_reg)
            S_LNK:
            begin
                ma = row_reg[0] ? s_reg : c_reg;
                mb = {16'd0, a_len};
            end
            S_MUL:
            begin
                nterms = 2'd3;
                ma     = t_reg[{row_reg, k_reg}][31:0];
                mb     = qsel(k_reg, col_reg[1:0], right, c_reg, s_reg, q03_reg, q13_reg,
                              d_len);
                if (col_reg[1:0] == 2'd3)
                begin
                    init = AW'(t_reg[{row_reg, 2'd3}]) <<< 28;
                end
            end
            S_JAC:
            begin
                nterms = 2'd2;
                if (k_reg == 2'd0)
                begin
                    ma = zs_reg[col_reg][a1];
                    mb = d_vec[a2];
                end
                else
                begin
                    ma   = zs_reg[col_reg][a2];
                    mb   = d_vec[a1];
                    msub = 1'b1;
                end
            end
            default: ma = '0;
        endcase
        sum      = sub_reg ? acc_reg - AW'(prod_reg) : acc_reg + AW'(prod_reg);
        rnd20    = (sum + (AW'(1) <<< 19)) >>> 20;
        rnd28    = (sum + (AW'(1) <<< 27)) >>> 28;
        mac_done = (k_reg == nterms);
    end

    assign last_link = cmd_reg.jacobian ? (link_reg == 3'd4) :
                                          (link_reg + 3'd1 == cmd_reg.count);
    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
    assign res_push = (state_reg == S_EMIT) && !res_full;
    assign start    = (cmd_pop && (cmd.jacobian || cmd.count != 3'd0)) ||
                      ((state_reg == S_COPY) && !last_link);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    state_next = start ? S_RED : S_EMIT;
                end
            end
            S_RED:
            begin
                if (in_range)
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (it_reg == IW'(ITER_N - 1))
                begin
                    state_next = S_CS;
                end
            end
            S_CS: state_next = S_LNK;
            S_LNK:
            begin
                if (mac_done && row_reg == 2'd1)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mac_done && row_reg == 2'd2 && col_reg[1:0] == 2'd3)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (!last_link)
                begin
                    state_next = S_RED;
                end
                else
                begin
                    state_next = cmd_reg.jacobian ? S_JAC : S_EMIT;
                end
            end
            S_JAC:
            begin
                if (mac_done && row_reg == 2'd2)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_push)
                begin
                    if (cmd_reg.jacobian)
                    begin
                        state_next = (col_reg == 3'd4) ? S_IDLE : S_JAC;
                    end
                    else
                    begin
                        state_next = (row_reg == 2'd2) ? S_IDLE : S_EMIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            base_height_reg <= 20'd115449;
            upper_arm_reg   <= 20'd166724;
            forearm_reg     <= 20'd157286;
            tool_reg        <= 20'd137363;
            elbow_reg       <= 13'd2617;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    djk_pkg::CFG_BASE_HEIGHT:      base_height_reg <= cfg_data;
                    djk_pkg::CFG_UPPER_ARM_LENGTH: upper_arm_reg   <= cfg_data;
                    djk_pkg::CFG_FOREARM_LENGTH:   forearm_reg     <= cfg_data;
                    djk_pkg::CFG_TOOL_LENGTH:      tool_reg        <= cfg_data;
                    djk_pkg::CFG_ELBOW_OFFSET:     elbow_reg       <= cfg_data[12:0];
                    default:                       elbow_reg       <= elbow_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            link_reg <= link_start;
            z_reg    <= z_start;
            x_reg    <= djk_pkg::GAIN_Q30;
            y_reg    <= '0;
            neg_reg  <= 1'b0;
            it_reg   <= '0;
            for (int r = 0; r < 3; r++)
            begin
                zs_reg[link_start][r] <= col2[r][31:0];
                os_reg[link_start][r] <= col3[r];
            end
        end
        case (state_reg)
            S_IDLE:
            begin
                row_reg <= '0;
                if (cmd_pop)
                begin
                    cmd_reg <= cmd;
                    for (int e = 0; e < 12; e++)
                    begin
                        t_reg[e] <= (e % 5 == 0) ? EW'(djk_pkg::ONE_Q) : '0;
                    end
                end
            end
            S_RED:
            begin
                if (z_reg > djk_pkg::PI_Q30)
                begin
                    z_reg <= z_reg - djk_pkg::TWO_PI_Q30;
                end
                else if (z_reg <= -djk_pkg::PI_Q30)
                begin
                    z_reg <= z_reg + djk_pkg::TWO_PI_Q30;
                end
                else if (z_reg > djk_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z_reg - djk_pkg::PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (z_reg < -djk_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z_reg + djk_pkg::PI_Q30;
                    neg_reg <= 1'b1;
                end
            end
            S_ROT:
            begin
                x_reg  <= x_step;
                y_reg  <= y_step;
                z_reg  <= z_step;
                it_reg <= it_reg + 1'b1;
            end
            S_CS:
            begin
                c_reg   <= neg_reg ? -xr[31:0] : xr[31:0];
                s_reg   <= neg_reg ? -yr[31:0] : yr[31:0];
                row_reg <= '0;
                col_reg <= '0;
                k_reg   <= '0;
            end
            S_COPY:
            begin
                for (int e = 0; e < 12; e++)
                begin
                    t_reg[e] <= nt_reg[e];
                end
                row_reg <= '0;
                col_reg <= '0;
                k_reg   <= '0;
            end
            S_EMIT:
            begin
                if (res_push)
                begin
                    if (cmd_reg.jacobian)
                    begin
                        col_reg <= col_reg + 3'd1;
                        row_reg <= '0;
                        k_reg   <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 2'd1;
                    end
                end
            end
            default: ;
        endcase

        if (state_reg == S_LNK || state_reg == S_MUL || state_reg == S_JAC)
        begin
            acc_reg <= (k_reg == 2'd0) ? init : sum;
            if (k_reg < nterms)
            begin
                prod_reg <= ma * mb;
                sub_reg  <= msub;
            end
            if (mac_done)
            begin
                k_reg <= '0;
                case (state_reg)
                    S_LNK:
                    begin
                        if (row_reg == 2'd0)
                        begin
                            q03_reg <= rnd20[EW-1:0];
                        end
                        else
                        begin
                            q13_reg <= rnd20[EW-1:0];
                        end
                        row_reg <= (row_reg == 2'd1) ? 2'd0 : row_reg + 2'd1;
                    end
                    S_MUL:
                    begin
                        nt_reg[{row_reg, col_reg[1:0]}] <= rnd28[EW-1:0];
                        if (col_reg[1:0] == 2'd3)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        lin_reg[row_reg] <= rnd28[LW-1:0];
                        if (row_reg != 2'd2)
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                endcase
            end
            else
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        if (cmd_reg.jacobian)
        begin
            res.line_index = col_reg;
            res.value_0    = djk_pkg::sat24(lin_reg[0]);
            res.value_1    = djk_pkg::sat24(lin_reg[1]);
            res.value_2    = djk_pkg::sat24(lin_reg[2]);
            res.value_3    = djk_pkg::sat24(LW'(zs_reg[col_reg][0]));
            res.value_4    = djk_pkg::sat24(LW'(zs_reg[col_reg][1]));
            res.value_5    = djk_pkg::sat24(LW'(zs_reg[col_reg][2]));
            res.last       = (col_reg == 3'd4);
        end
        else
        begin
            res.line_index = {1'b0, row_reg};
            res.value_0    = djk_pkg::sat24(LW'(t_reg[{row_reg, 2'd0}]));
            res.value_1    = djk_pkg::sat24(LW'(t_reg[{row_reg, 2'd1}]));
            res.value_2    = djk_pkg::sat24(LW'(t_reg[{row_reg, 2'd2}]));
            res.value_3    = djk_pkg::sat24(LW'(t_reg[{row_reg, 2'd3}]));
            res.value_4    = '0;
            res.value_5    = '0;
            res.last       = (row_reg == 2'd2);
        end
    end

endmodule

FILE: rtl/dh_arm_kinematics_jacobian.sv
// Forward pose and geometric Jacobian of a five-joint arm. The front queue takes one
// request per beat while it is not full; the back end works on one request at a time.
// Each chained link runs through angle reduction, the CORDIC iterations, a rounding
// step, the single shared multiplier for the link terms and the 3x4 matrix product,
// and a copy step. A pose request chains as many links as its frame count (at most
// five); a Jacobian request always chains all five links and then computes each
// column in turn. Results leave through a two-beat queue, and a full result queue
// stalls the back end.
module dh_arm_kinematics_jacobian #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  djk_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output djk_pkg::result_t  result,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [19:0]       cfg_data
);

    djk_pkg::cmd_t                       cmd;
    logic                                cmd_empty, cmd_pop;
    djk_pkg::result_t                    res;
    logic                                res_full, res_push;
    logic [$bits(djk_pkg::result_t)-1:0] out_rdata;

    djk_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd),
        .cmd_empty(cmd_empty)
    );

    djk_back #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res      (res),
        .res_full (res_full),
        .res_push (res_push)
    );

    djk_fifo #(
        .WIDTH($bits(djk_pkg::result_t)),
        .DEPTH(2)
    ) u_out_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (res_push),
        .wdata(res),
        .full (res_full),
        .rd   (pop),
        .rdata(out_rdata),
        .empty(empty)
    );

    assign result = djk_pkg::result_t'(out_rdata);

endmodule
